>>> rtl/core/utli_pkg.sv
// Types and constants shared by the uniform table linear interpolator.
package utli_pkg;

  localparam int unsigned FieldW  = 32;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned PtsW    = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FracW   = 16;

  localparam logic [FieldW-1:0] RangeStartRst = 32'sd0;
  localparam logic [FieldW-1:0] RangeEndRst   = 32'sd16777216;
  localparam logic [FieldW-1:0] StepInvRst    = 32'd65536;
  localparam logic [PtsW-1:0]   PointsRst     = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_INTERP = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANGE_START = 2'd0,
    CFG_RANGE_END   = 2'd1,
    CFG_STEP_INV    = 2'd2,
    CFG_POINTS      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_FIRST = 2'd1,
    SEL_LAST  = 2'd2,
    SEL_BLEND = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic [1:0]               func;
    logic [IdxW-1:0]          entry_index;
    logic signed [FieldW-1:0] entry_value;
    logic signed [FieldW-1:0] x_value;
  } in_req_t;

  typedef struct packed {
    logic signed [FieldW-1:0] result_value;
    logic [IdxW-1:0]          cell_index;
    logic                     out_of_range;
  } out_rsp_t;

endpackage

>>> rtl/core/utli_sample_ram.sv
// Sample table RAM: one write port, two registered read ports.
module utli_sample_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [DataW-1:0] rdata0_o,
  output logic [DataW-1:0] rdata1_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

>>> rtl/core/uniform_table_linear_interpolator_core.sv
// Uniform-grid linear interpolation table: config, 4-stage pipeline, sample RAM.
// A request passes through the stage 1, 2 and 3 registers and the output register before its result is valid.
// Throughput: one request per cycle when not stalled; stage 0 holds the 32x32 scale multiply,
// stage 1 issues the dual-port RAM read of both neighbors, stage 2 the blend multiply.
// Reset clears the pipeline valids and loads the config defaults.
// Sample RAM is not cleared; entries are undefined until written.
module uniform_table_linear_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [utli_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [utli_pkg::FieldW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  utli_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output utli_pkg::out_rsp_t                  out_rsp_o
);

  localparam int unsigned FieldW  = utli_pkg::FieldW;
  localparam int unsigned IdxW    = utli_pkg::IdxW;
  localparam int unsigned FracW   = utli_pkg::FracW;
  localparam int unsigned AddrW   = $clog2(TABLE_DEPTH);
  localparam int unsigned PntW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SampleW = (VALUE_WIDTH < FieldW) ? VALUE_WIDTH : FieldW;
  localparam int unsigned ProdW   = 2 * FieldW;
  localparam int unsigned MulW    = SampleW + FracW + 2;

  // config
  logic signed [FieldW-1:0]     cfg_start_q;
  logic signed [FieldW-1:0]     cfg_end_q;
  logic [FieldW-1:0]            cfg_step_q;
  logic [utli_pkg::PtsW-1:0]    cfg_points_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q  <= utli_pkg::RangeStartRst;
      cfg_end_q    <= utli_pkg::RangeEndRst;
      cfg_step_q   <= utli_pkg::StepInvRst;
      cfg_points_q <= utli_pkg::PointsRst;
    end else if (cfg_we_i) begin
      unique case (utli_pkg::cfg_reg_e'(cfg_idx_i))
        utli_pkg::CFG_RANGE_START: cfg_start_q  <= cfg_wdata_i;
        utli_pkg::CFG_RANGE_END:   cfg_end_q    <= cfg_wdata_i;
        utli_pkg::CFG_STEP_INV:    cfg_step_q   <= cfg_wdata_i;
        utli_pkg::CFG_POINTS:      cfg_points_q <= cfg_wdata_i[utli_pkg::PtsW-1:0];
        default: ;
      endcase
    end
  end

  // effective point count, clamped to [2, TABLE_DEPTH]
  logic [PntW-1:0] p_eff;
  logic [PntW-1:0] p_m2;

  always_comb begin
    if (cfg_points_q < utli_pkg::PtsW'(2)) begin
      p_eff = PntW'(2);
    end else if (32'(cfg_points_q) > 32'(TABLE_DEPTH)) begin
      p_eff = PntW'(TABLE_DEPTH);
    end else begin
      p_eff = PntW'(cfg_points_q);
    end
  end

  assign p_m2 = p_eff - PntW'(2);

  // handshake chain
  logic s1_v_q, s2_v_q, s3_v_q, out_valid_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy    = !out_valid_q || out_ready_i;
  assign s3_rdy     = !s3_v_q || out_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  // stage 0: range check and grid scaling
  logic [FieldW:0]   in_dist_ext;
  logic [FieldW-1:0] in_dist;
  logic [ProdW-1:0]  in_prod;
  logic              in_xoor;

  assign in_xoor     = (in_req_i.x_value < cfg_start_q) || (in_req_i.x_value >= cfg_end_q);
  assign in_dist_ext = {in_req_i.x_value[FieldW-1], in_req_i.x_value}
                     - {cfg_start_q[FieldW-1], cfg_start_q};
  assign in_dist     = in_dist_ext[FieldW-1:0];
  assign in_prod     = ProdW'(in_dist) * ProdW'(cfg_step_q);

  logic [1:0]         s1_func_q;
  logic [IdxW-1:0]    s1_slot_q;
  logic [SampleW-1:0] s1_wdata_q;
  logic [ProdW-1:0]   s1_prod_q;
  logic               s1_xoor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_func_q  <= in_req_i.func;
      s1_slot_q  <= in_req_i.entry_index;
      s1_wdata_q <= in_req_i.entry_value[SampleW-1:0];
      s1_prod_q  <= in_prod;
      s1_xoor_q  <= in_xoor;
    end
  end

  // stage 1: cell locate, RAM access, result decode
  logic [FieldW-1:0]  s1_cell_raw;
  logic [FracW-1:0]   s1_frac;
  logic               s1_tail;
  logic [AddrW-1:0]   s1_cell;
  logic [AddrW-1:0]   s1_slot_addr;
  logic               s1_slot_in_tbl;
  logic               s1_slot_oor;
  logic               s1_adv;
  utli_pkg::res_sel_e s1_sel;
  logic [IdxW-1:0]    s1_cell_out;
  logic               s1_oor;

  assign s1_cell_raw    = s1_prod_q[ProdW-1:FieldW];
  assign s1_frac        = s1_prod_q[FieldW-1:FieldW-FracW];
  assign s1_tail        = s1_cell_raw > 32'(p_m2);
  assign s1_cell        = s1_tail ? AddrW'(p_m2) : AddrW'(s1_cell_raw);
  assign s1_slot_addr   = AddrW'(s1_slot_q);
  assign s1_slot_in_tbl = 32'(s1_slot_q) < 32'(TABLE_DEPTH);
  assign s1_slot_oor    = 32'(s1_slot_q) >= 32'(p_eff);
  assign s1_adv         = s1_v_q && s2_rdy;

  always_comb begin
    unique case (utli_pkg::func_e'(s1_func_q))
      utli_pkg::FUNC_WRITE: begin
        s1_sel      = utli_pkg::SEL_ZERO;
        s1_cell_out = s1_slot_q;
        s1_oor      = s1_slot_oor;
      end
      utli_pkg::FUNC_READ: begin
        s1_sel      = s1_slot_oor ? utli_pkg::SEL_ZERO : utli_pkg::SEL_FIRST;
        s1_cell_out = s1_slot_q;
        s1_oor      = s1_slot_oor;
      end
      utli_pkg::FUNC_INTERP: begin
        if (s1_xoor_q) begin
          s1_sel      = utli_pkg::SEL_ZERO;
          s1_cell_out = '0;
          s1_oor      = 1'b1;
        end else begin
          s1_sel      = s1_tail ? utli_pkg::SEL_LAST : utli_pkg::SEL_BLEND;
          s1_cell_out = IdxW'(s1_cell);
          s1_oor      = 1'b0;
        end
      end
      default: begin
        s1_sel      = utli_pkg::SEL_ZERO;
        s1_cell_out = '0;
        s1_oor      = 1'b1;
      end
    endcase
  end

  // writes and reads both issue from stage 1, so program order is kept
  logic               ram_we;
  logic               ram_re;
  logic [AddrW-1:0]   ram_raddr0;
  logic [AddrW-1:0]   ram_raddr1;
  logic [SampleW-1:0] ram_rdata0;
  logic [SampleW-1:0] ram_rdata1;

  assign ram_we     = s1_adv && (s1_func_q == utli_pkg::FUNC_WRITE) && s1_slot_in_tbl;
  assign ram_re     = s1_adv;
  assign ram_raddr0 = (s1_func_q == utli_pkg::FUNC_READ) ? s1_slot_addr : s1_cell;
  assign ram_raddr1 = s1_cell + AddrW'(1);

  utli_sample_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW),
    .DataW (SampleW)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (s1_slot_addr),
    .wdata_i  (s1_wdata_q),
    .re_i     (ram_re),
    .raddr0_i (ram_raddr0),
    .raddr1_i (ram_raddr1),
    .rdata0_o (ram_rdata0),
    .rdata1_o (ram_rdata1)
  );

  utli_pkg::res_sel_e s2_sel_q;
  logic [IdxW-1:0]    s2_cell_q;
  logic               s2_oor_q;
  logic [FracW-1:0]   s2_frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_sel_q  <= s1_sel;
      s2_cell_q <= s1_cell_out;
      s2_oor_q  <= s1_oor;
      s2_frac_q <= s1_frac;
    end
  end

  // stage 2: neighbor difference times fraction
  logic signed [SampleW-1:0] s2_y0;
  logic signed [SampleW-1:0] s2_y1;
  logic signed [SampleW:0]   s2_diff;
  logic signed [MulW-1:0]    s2_mul;
  logic signed [SampleW-1:0] s2_base;
  logic                      s2_adv;

  assign s2_y0   = ram_rdata0;
  assign s2_y1   = ram_rdata1;
  assign s2_diff = (SampleW+1)'(s2_y1) - (SampleW+1)'(s2_y0);
  assign s2_mul  = s2_diff * $signed({1'b0, s2_frac_q});
  assign s2_adv  = s2_v_q && s3_rdy;

  always_comb begin
    case (s2_sel_q) inside
      utli_pkg::SEL_FIRST, utli_pkg::SEL_BLEND: s2_base = s2_y0;
      utli_pkg::SEL_LAST:                       s2_base = s2_y1;
      default:                                  s2_base = '0;
    endcase
  end

  logic                      s3_blend_q;
  logic signed [SampleW-1:0] s3_base_q;
  logic signed [MulW-1:0]    s3_mul_q;
  logic [IdxW-1:0]           s3_cell_q;
  logic                      s3_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_blend_q <= (s2_sel_q == utli_pkg::SEL_BLEND);
      s3_base_q  <= s2_base;
      s3_mul_q   <= s2_mul;
      s3_cell_q  <= s2_cell_q;
      s3_oor_q   <= s2_oor_q;
    end
  end

  // stage 3: y0 + floor(diff * frac / 2^16) for a blend, else the selected base value
  logic signed [MulW-1:0]    s3_shift;
  logic signed [SampleW+1:0] s3_sum;
  logic signed [SampleW-1:0] s3_val;
  utli_pkg::out_rsp_t        s3_rsp;

  assign s3_shift = s3_mul_q >>> FracW;
  assign s3_sum   = (SampleW+2)'(s3_base_q) + (SampleW+2)'(s3_shift);
  assign s3_val   = s3_blend_q ? s3_sum[SampleW-1:0] : s3_base_q;

  always_comb begin
    s3_rsp.result_value = FieldW'(s3_val);
    s3_rsp.cell_index   = s3_cell_q;
    s3_rsp.out_of_range = s3_oor_q;
  end

  utli_pkg::out_rsp_t out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s3_v_q) begin
      out_rsp_q <= s3_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_v_q)
    else $error("accepted request did not reach stage 1");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !s3_rdy |=> s2_v_q && $stable(s2_cell_q) && $stable(ram_rdata0))
    else $error("stalled stage 2 lost its contents");

  a_last_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && s2_sel_q == utli_pkg::SEL_LAST |-> !s2_oor_q)
    else $error("clamped cell flagged out of range");

  a_blend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && s3_blend_q |-> !s3_oor_q)
    else $error("blend result flagged out of range");

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the uniform table interpolator: table preload, directed cases, random lookups.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FieldW        = utli_pkg::FieldW;
  localparam int unsigned IdxW          = utli_pkg::IdxW;
  localparam int unsigned PtsW          = utli_pkg::PtsW;
  localparam int unsigned Depth         = 1024;
  localparam int unsigned LoadSlots     = 64;
  localparam int unsigned ReqPerConfig  = 62;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [1:0]  FuncUndef     = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  utli_pkg::cfg_reg_e cfg_idx_i   = utli_pkg::CFG_RANGE_START;
  logic [FieldW-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  utli_pkg::in_req_t  in_req_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  utli_pkg::out_rsp_t out_rsp_o;

  uniform_table_linear_interpolator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // shadow of the block's table and registers
  logic signed [FieldW-1:0] samples [Depth];
  bit                       written [Depth];
  logic signed [FieldW-1:0] range_lo = utli_pkg::RangeStartRst;
  logic signed [FieldW-1:0] range_hi = utli_pkg::RangeEndRst;
  logic [FieldW-1:0]        step_inv = utli_pkg::StepInvRst;
  logic [PtsW-1:0]          npoints  = utli_pkg::PointsRst;

  utli_pkg::out_rsp_t expected_rsp_q [$];
  int unsigned src_idle_pct  = 22;
  int unsigned sink_idle_pct = 51;
  int unsigned err_count     = 0;
  int unsigned rsp_seen      = 0;
  int unsigned flagged_count = 0;
  int unsigned cfg_count     = 0;
  int unsigned func_count [4] = '{0, 0, 0, 0};
  int unsigned stall_cycles  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_points();
    if (npoints < 2) return 2;
    if (npoints > Depth) return Depth;
    return npoints;
  endfunction

  function automatic utli_pkg::out_rsp_t compute_lookup(input utli_pkg::in_req_t r);
    utli_pkg::out_rsp_t rsp;
    int unsigned p;
    int unsigned cell_n;
    longint      xs;
    longint      y0;
    longint      y1;
    longint      blend;
    logic [63:0] dxu;
    logic [63:0] prod;
    p   = eff_points();
    rsp = '0;
    case (r.func)
      utli_pkg::FUNC_WRITE: begin
        samples[r.entry_index] = r.entry_value;
        written[r.entry_index] = 1'b1;
        rsp.cell_index   = r.entry_index;
        rsp.out_of_range = (r.entry_index >= p);
      end
      utli_pkg::FUNC_READ: begin
        rsp.cell_index = r.entry_index;
        if (r.entry_index >= p) begin
          rsp.out_of_range = 1'b1;
        end else begin
          rsp.result_value = samples[r.entry_index];
        end
      end
      utli_pkg::FUNC_INTERP: begin
        xs = longint'(signed'(r.x_value));
        if (xs < longint'(range_lo) || xs >= longint'(range_hi)) begin
          rsp.out_of_range = 1'b1;
        end else begin
          dxu  = xs - longint'(range_lo);
          prod = dxu * {32'b0, step_inv};
          if (prod[63:32] > p - 2) begin
            rsp.result_value = samples[p-1];
            rsp.cell_index   = IdxW'(p - 2);
          end else begin
            cell_n = prod[63:32];
            y0     = longint'(samples[cell_n]);
            y1     = longint'(samples[cell_n+1]);
            blend  = (y1 - y0) * longint'({1'b0, prod[31:16]});
            rsp.result_value = 32'(y0 + (blend >>> 16));
            rsp.cell_index   = IdxW'(cell_n);
          end
        end
      end
      default: rsp.out_of_range = 1'b1;
    endcase
    return rsp;
  endfunction

  // first sample the request would read that was never written, else Depth
  function automatic int unsigned unwritten_use(input utli_pkg::in_req_t r);
    int unsigned p;
    int unsigned cell_n;
    longint      xs;
    logic [63:0] prod;
    p = eff_points();
    if (r.func == utli_pkg::FUNC_READ) begin
      if (r.entry_index < p && !written[r.entry_index]) return r.entry_index;
    end else if (r.func == utli_pkg::FUNC_INTERP) begin
      xs = longint'(r.x_value);
      if (xs >= longint'(range_lo) && xs < longint'(range_hi)) begin
        prod = 64'(xs - longint'(range_lo)) * {32'b0, step_inv};
        if (prod[63:32] > p - 2) begin
          if (!written[p-1]) return p - 1;
        end else begin
          cell_n = prod[63:32];
          if (!written[cell_n]) return cell_n;
          if (!written[cell_n+1]) return cell_n + 1;
        end
      end
    end
    return Depth;
  endfunction

  function automatic utli_pkg::in_req_t mk_req(input logic [1:0] f, input logic [IdxW-1:0] idx,
                                               input logic [31:0] val, input logic [31:0] x);
    utli_pkg::in_req_t r;
    r.func        = f;
    r.entry_index = idx;
    r.entry_value = val;
    r.x_value     = x;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d, %s: got 0x%0h, want 0x%0h", rsp_seen, what, got, want);
    err_count++;
  endtask

  // receiver backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    utli_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsp_seen++;
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("no request pending", out_rsp_o, 0);
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_rsp_o.result_value !== want.result_value)
          report_mismatch("result_value", out_rsp_o.result_value, want.result_value);
        if (out_rsp_o.cell_index !== want.cell_index)
          report_mismatch("cell_index", out_rsp_o.cell_index, want.cell_index);
        if (out_rsp_o.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", out_rsp_o.out_of_range, want.out_of_range);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no request or result moved for %0d cycles", stall_cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic push_request(input utli_pkg::in_req_t r);
    utli_pkg::out_rsp_t rsp;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rsp = compute_lookup(r);
    expected_rsp_q.push_back(rsp);
    func_count[r.func]++;
    flagged_count += rsp.out_of_range;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input utli_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      utli_pkg::CFG_RANGE_START: range_lo = data;
      utli_pkg::CFG_RANGE_END:   range_hi = data;
      utli_pkg::CFG_STEP_INV:    step_inv = data;
      utli_pkg::CFG_POINTS:      npoints  = data[PtsW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] rs, input logic [31:0] re,
                            input logic [31:0] si, input logic [31:0] pw);
    drain_pipeline();
    write_reg(utli_pkg::CFG_RANGE_START, rs);
    write_reg(utli_pkg::CFG_RANGE_END, re);
    write_reg(utli_pkg::CFG_STEP_INV, si);
    write_reg(utli_pkg::CFG_POINTS, pw);
    cfg_we_i <= 1'b0;
    cfg_count++;
  endtask

  // low slots and the slots the directed cases read get a sample first
  task automatic test_table_load();
    for (int i = 0; i < LoadSlots; i++) begin
      push_request(mk_req(utli_pkg::FUNC_WRITE, IdxW'(i), $urandom, $urandom));
    end
    push_request(mk_req(utli_pkg::FUNC_WRITE, 10'd255, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_WRITE, 10'd256, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_WRITE, 10'd1023, $urandom, $urandom));
  endtask

  task automatic test_access_ops();
    push_request(mk_req(utli_pkg::FUNC_WRITE, 10'd0, 32'h7fff_ffff, 32'h0));
    push_request(mk_req(utli_pkg::FUNC_WRITE, 10'd1, 32'h8000_0000, 32'hffff_ffff));
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd0, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd1, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd1023, $urandom, $urandom));
    push_request(mk_req(FuncUndef, 10'h3ff, $urandom, $urandom));
  endtask

  // reset config: start 0, end 256.0, unit step, full table
  task automatic test_interp_edges();
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h0000_0000));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h0000_8000));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h00ff_ffff));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'hffff_ffff));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h0100_0000));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h7fff_ffff));
  endtask

  task automatic test_point_count();
    set_config(32'h0, 32'h0100_0000, 32'h0001_0000, 32'd5);
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd4, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd5, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_WRITE, 10'd900, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd900, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h00c8_0000));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h0003_ffff));
    set_config(32'h0, 32'h0100_0000, 32'h0001_0000, 32'd0);
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h000a_0000));
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd2, $urandom, $urandom));
    set_config(32'h0, 32'h0100_0000, 32'h0001_0000, 32'd2047);
    push_request(mk_req(utli_pkg::FUNC_READ, 10'd1023, $urandom, $urandom));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h00ff_8000));
  endtask

  task automatic test_range_config();
    set_config(32'h100, 32'h100, 32'h0001_0000, 32'd1024);
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h100));
    set_config(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd1024);
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h8000_0000));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h7fff_fffe));
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h7fff_ffff));
    set_config(32'hffff_0000, 32'h0010_0000, 32'h0, 32'd1024);
    push_request(mk_req(utli_pkg::FUNC_INTERP, 10'd0, $urandom, 32'h0008_1234));
  endtask

  task automatic random_config();
    longint      rs;
    longint      re;
    logic [31:0] si;
    logic [10:0] pts;
    logic [31:0] pw;
    int unsigned p;
    case ($urandom_range(0, 7))
      0:       pts = 11'd2;
      1:       pts = 11'($urandom_range(0, 1));
      2:       pts = 11'd1024;
      3:       pts = 11'($urandom_range(1025, 2047));
      default: pts = 11'($urandom_range(3, 64));
    endcase
    p  = (pts < 2) ? 2 : (pts > Depth) ? Depth : pts;
    rs = longint'($urandom_range(0, 33554432)) - 16777216;
    case ($urandom_range(0, 4))
      0: begin
        si = 32'h0001_0000;
        re = rs + (longint'(p) << 16) + $urandom_range(0, 65535);
      end
      1: begin
        si = $urandom_range(4096, 262144);
        re = rs + (longint'(p) << 32) / si + $urandom_range(0, 65535);
      end
      2: begin
        rs = longint'(signed'($urandom));
        re = longint'(signed'($urandom));
        si = $urandom;
      end
      3: begin
        si = 32'h0;
        re = rs + $urandom_range(1, 16777216);
      end
      default: begin
        rs = -2147483648;
        re = 2147483647;
        si = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h1;
      end
    endcase
    if (re > 2147483647) re = 2147483647;
    pw = $urandom_range(0, 1) ? {21'($urandom), pts} : {21'b0, pts};
    set_config(rs[31:0], re[31:0], si, pw);
  endtask

  function automatic utli_pkg::in_req_t rand_req();
    utli_pkg::in_req_t r;
    int unsigned p;
    int unsigned pick;
    int unsigned miss;
    longint      span;
    longint      off;
    p    = eff_points();
    r    = mk_req(utli_pkg::FUNC_INTERP, 10'($urandom), $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick >= 92) r.func = FuncUndef;
    else if (pick >= 70) r.func = utli_pkg::FUNC_WRITE;
    else if (pick >= 45) r.func = utli_pkg::FUNC_READ;
    if ($urandom_range(99) < 85) r.entry_index = IdxW'($urandom_range(0, p - 1));
    span = longint'(range_hi) - longint'(range_lo);
    pick = $urandom_range(99);
    if (span > 0 && pick < 75) begin
      off       = longint'({$urandom, $urandom} >> 1) % span;
      r.x_value = 32'(longint'(range_lo) + off);
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0:       r.x_value = range_lo;
        1:       r.x_value = range_hi - 1;
        2:       r.x_value = range_lo - 1;
        default: r.x_value = range_hi;
      endcase
    end
    // fill a sample first where the lookup would touch one never written
    miss = unwritten_use(r);
    if (miss < Depth) begin
      r.func        = utli_pkg::FUNC_WRITE;
      r.entry_index = IdxW'(miss);
    end
    return r;
  endfunction

  task automatic test_random();
    int unsigned src_pct [3]  = '{22, 51, 0};
    int unsigned sink_pct [3] = '{51, 22, 0};
    for (int m = 0; m < 3; m++) begin
      src_idle_pct  = src_pct[m];
      sink_idle_pct = sink_pct[m];
      for (int c = 0; c < 3; c++) begin
        random_config();
        repeat (ReqPerConfig) push_request(rand_req());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_table_load();
    test_access_ops();
    test_interp_edges();
    test_point_count();
    test_range_config();
    test_random();
    drain_pipeline();
    $display("covered %0d writes, %0d interpolations, %0d reads, %0d undefined codes",
             func_count[utli_pkg::FUNC_WRITE], func_count[utli_pkg::FUNC_INTERP],
             func_count[utli_pkg::FUNC_READ], func_count[FuncUndef]);
    $display("%0d results checked, %0d flagged, %0d register settings, %0d mismatches",
             rsp_seen, flagged_count, cfg_count, err_count);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/utli_pkg.sv
rtl/core/utli_sample_ram.sv
rtl/core/uniform_table_linear_interpolator_core.sv
tb/sv/tb_top.sv
